// ===== design/fft_grid_size_select_assert.svh =====
// Assertion macros for the FFT grid size selector.
// Used by the top level; expects clk and rst in the including scope.
`ifndef FFT_GRID_SIZE_SELECT_ASSERT_SVH
`define FFT_GRID_SIZE_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FGSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FGSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FGSS_ASSERT(lbl, prop, msg)
`define FGSS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== design/fgss_pkg.sv =====
// Shared types, constants and helper functions for the FFT grid size selector.
// No dependencies.
package fgss_pkg;

  localparam int unsigned SEARCH_LIMIT_DEFAULT = 8192;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned GRID_W = 13;
  localparam int unsigned PROC_W = 11;
  localparam int unsigned STAT_W = 3;

  // 1000*len + 999*sp < 2^43, 1000*sp < 2^42
  localparam int unsigned DIV_NW = 43;
  localparam int unsigned DIV_DW = 42;
  localparam int unsigned SCALE  = 1000;

  localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SPACING  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_DIVISIBLE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE     = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0]  box_x;
    logic [LEN_W-1:0]  box_y;
    logic [LEN_W-1:0]  box_z;
    logic [LEN_W-1:0]  spacing;
    logic [GRID_W-1:0] req_x;
    logic [GRID_W-1:0] req_y;
    logic [GRID_W-1:0] req_z;
    logic [PROC_W-1:0] proc_count;
  } item_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [GRID_W-1:0] grid_z;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  // Inverse of an odd value modulo 2^64 (Newton iteration).
  function automatic logic [63:0] odd_inverse(input logic [63:0] d);
    logic [63:0] x;
    x = d;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - d * x);
    end
    return x;
  endfunction

endpackage

// ===== design/fft_grid_size_select.sv =====
// FFT grid size selector: top level with the control sequencer.
// Instantiates fgss_div and fgss_smooth; depends on fgss_pkg and the assert header.
//
// One request on item (valid/ready) gives one result on result (valid/ready).
// item_ready is high only while the sequencer is idle; one request is worked
// at a time. Per request: three minimum-count divisions through the shared
// divider, up to two request divisibility checks, then for each free axis
// one start-offset division (x and y) and a candidate scan from max(1, nmin)
// up to, but not including, the scan limit max(1, 2 * largest nmin). A
// candidate that fails the processor-count test is skipped; one that passes
// goes through the smoothness unit, which strips its 2, 3, 5, 7 factors.
// Zero spacing goes straight to the result.
// The result sits in an output register; a stalled receiver holds the
// sequencer in its last step, and a new request is taken once it is idle.
// Reset is synchronous and returns the block to idle with no result pending.
`include "fft_grid_size_select_assert.svh"

module fft_grid_size_select #(
  parameter int unsigned SEARCH_LIMIT = fgss_pkg::SEARCH_LIMIT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fgss_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output fgss_pkg::result_t result
);
  import fgss_pkg::*;

  localparam int unsigned NW = $clog2(SEARCH_LIMIT + 1);
  localparam logic [DIV_NW:0] LIMIT_MAX = (DIV_NW + 1)'(SEARCH_LIMIT);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_NMIN_GO   = 4'd1;
  localparam logic [3:0] S_NMIN_WAIT = 4'd2;
  localparam logic [3:0] S_CHECK     = 4'd3;
  localparam logic [3:0] S_REQ_GO    = 4'd4;
  localparam logic [3:0] S_REQ_WAIT  = 4'd5;
  localparam logic [3:0] S_SEL       = 4'd6;
  localparam logic [3:0] S_POS_WAIT  = 4'd7;
  localparam logic [3:0] S_CAND      = 4'd8;
  localparam logic [3:0] S_SMOOTH    = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0]        state;
  logic [1:0]        dim;
  logic [LEN_W-1:0]  box [3];
  logic [LEN_W-1:0]  sp;
  logic [DIV_DW-1:0] den_sp;
  logic [GRID_W-1:0] req [3];
  logic [PROC_W-1:0] procs;
  logic [NW-1:0]     nmin [3];
  logic [DIV_NW-1:0] maxq;
  logic [NW-1:0]     limit;
  logic [NW-1:0]     n;
  logic [PROC_W-1:0] rem;
  logic [GRID_W-1:0] grid [3];
  logic [STAT_W-1:0] status;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              sm_start;
  logic              sm_done;
  logic              sm_smooth;

  logic [NW-1:0]     n_start;
  logic [PROC_W-1:0] rem_inc;
  logic [PROC_W-1:0] rem_step;
  logic              need_div;
  logic [DIV_NW:0]   twice_max;

  assign item_ready = (state == S_IDLE);
  assign n_start    = (nmin[dim] == '0) ? NW'(1) : nmin[dim];
  assign rem_inc    = rem + 1'b1;
  assign rem_step   = (rem_inc == procs) ? '0 : rem_inc;
  assign need_div   = (dim != 2'd2);
  assign twice_max  = {maxq, 1'b0};
  assign sm_start   = (state == S_CAND) && (n < limit) && !(need_div && rem != '0);

  always_comb begin
    div_req = '0;
    case (state)
      S_NMIN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(box[dim]) * DIV_NW'(SCALE) + DIV_NW'(den_sp)
                        - DIV_NW'(sp);
        div_req.den   = den_sp;
      end
      S_REQ_GO: begin
        div_req.start = (req[dim] != '0);
        div_req.num   = DIV_NW'(req[dim]);
        div_req.den   = DIV_DW'(procs);
      end
      S_SEL: begin
        div_req.start = (req[dim] == '0) && need_div;
        div_req.num   = DIV_NW'(n_start);
        div_req.den   = DIV_DW'(procs);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  fgss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fgss_smooth #(.W(NW)) u_smooth (
    .clk    (clk),
    .rst    (rst),
    .start  (sm_start),
    .value  (n),
    .done   (sm_done),
    .smooth (sm_smooth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dim          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            box[0] <= item.box_x;
            box[1] <= item.box_y;
            box[2] <= item.box_z;
            sp     <= item.spacing;
            req[0] <= item.req_x;
            req[1] <= item.req_y;
            req[2] <= item.req_z;
            procs  <= (item.proc_count == '0) ? PROC_W'(1) : item.proc_count;
            den_sp <= DIV_DW'(item.spacing) * DIV_DW'(SCALE);
            maxq   <= '0;
            dim    <= '0;
            if (item.spacing == '0) begin
              status <= ST_ZERO_SPACING;
              state  <= S_OUT;
            end else begin
              status <= ST_OK;
              state  <= S_NMIN_GO;
            end
          end
        end
        S_NMIN_GO: begin
          state <= S_NMIN_WAIT;
        end
        S_NMIN_WAIT: begin
          if (div_rsp.done) begin
            nmin[dim] <= NW'(div_rsp.quo);
            if (div_rsp.quo > maxq) begin
              maxq <= div_rsp.quo;
            end
            if (dim == 2'd2) begin
              dim   <= '0;
              state <= S_CHECK;
            end else begin
              dim   <= dim + 1'b1;
              state <= S_NMIN_GO;
            end
          end
        end
        S_CHECK: begin
          limit <= (maxq == '0) ? NW'(1) : NW'(twice_max);
          if (twice_max > LIMIT_MAX) begin
            status <= ST_TOO_LARGE;
            state  <= S_OUT;
          end else begin
            state <= S_REQ_GO;
          end
        end
        S_REQ_GO: begin
          if (req[dim] != '0) begin
            state <= S_REQ_WAIT;
          end else if (dim == 2'd1) begin
            dim   <= '0;
            state <= S_SEL;
          end else begin
            dim <= dim + 1'b1;
          end
        end
        S_REQ_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0) begin
              status <= ST_NOT_DIVISIBLE;
              state  <= S_OUT;
            end else if (dim == 2'd1) begin
              dim   <= '0;
              state <= S_SEL;
            end else begin
              dim   <= dim + 1'b1;
              state <= S_REQ_GO;
            end
          end
        end
        S_SEL: begin
          if (req[dim] != '0) begin
            grid[dim] <= req[dim];
            if (dim == 2'd2) begin
              state <= S_OUT;
            end else begin
              dim <= dim + 1'b1;
            end
          end else begin
            n <= n_start;
            if (need_div) begin
              state <= S_POS_WAIT;
            end else begin
              rem   <= '0;
              state <= S_CAND;
            end
          end
        end
        S_POS_WAIT: begin
          if (div_rsp.done) begin
            rem   <= PROC_W'(div_rsp.rem);
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if (n >= limit) begin
            status <= ST_NONE_FOUND;
            state  <= S_OUT;
          end else if (need_div && rem != '0) begin
            n   <= n + 1'b1;
            rem <= rem_step;
          end else begin
            state <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          if (sm_done) begin
            if (sm_smooth) begin
              grid[dim] <= GRID_W'(n);
              if (dim == 2'd2) begin
                state <= S_OUT;
              end else begin
                dim   <= dim + 1'b1;
                state <= S_SEL;
              end
            end else begin
              n     <= n + 1'b1;
              rem   <= rem_step;
              state <= S_CAND;
            end
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid  <= 1'b1;
            result.status <= status;
            result.grid_x <= (status == ST_OK) ? grid[0] : '0;
            result.grid_y <= (status == ST_OK) ? grid[1] : '0;
            result.grid_z <= (status == ST_OK) ? grid[2] : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FGSS_ASSERT(a_err_zero_grid, result_valid && result.status != ST_OK |-> result.grid_x == '0 && result.grid_y == '0 && result.grid_z == '0, "error result carries nonzero grid")
  `FGSS_ASSERT(a_div_idle_start, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `FGSS_ASSERT_RST(a_reset_idle, rst |=> !result_valid && item_ready, "block not idle after reset")

endmodule

// ===== design/fgss_div.sv =====
// Restoring radix-2 divider shared by the grid size sequencer.
// One quotient bit per cycle; depends on fgss_pkg.
module fgss_div (
  input  logic                clk,
  input  logic                rst,
  input  fgss_pkg::div_req_t  req,
  output fgss_pkg::div_rsp_t  rsp
);
  import fgss_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic              busy;
  logic              done;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] den;

  logic [DIV_DW:0]   part;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign part = {rem, quo[DIV_NW-1]};
  assign ge   = part >= {1'b0, den};
  assign diff = part - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW);
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DW-1:0] : part[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ===== design/fgss_smooth.sv =====
// 7-smooth test: strips factors 2, 3, 5, 7 one per cycle.
// Exact division by 3, 5, 7 via modular inverse multiply; depends on fgss_pkg.
module fgss_smooth #(
  parameter int unsigned W = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] value,
  output logic         done,
  output logic         smooth
);
  import fgss_pkg::*;

  localparam logic [1:0] P2 = 2'd0;
  localparam logic [1:0] P3 = 2'd1;
  localparam logic [1:0] P5 = 2'd2;
  localparam logic [1:0] P7 = 2'd3;

  localparam logic [W-1:0] INV3 = W'(odd_inverse(64'd3));
  localparam logic [W-1:0] INV5 = W'(odd_inverse(64'd5));
  localparam logic [W-1:0] INV7 = W'(odd_inverse(64'd7));
  localparam logic [W-1:0] LIM3 = W'(((64'd1 << W) - 64'd1) / 64'd3);
  localparam logic [W-1:0] LIM5 = W'(((64'd1 << W) - 64'd1) / 64'd5);
  localparam logic [W-1:0] LIM7 = W'(((64'd1 << W) - 64'd1) / 64'd7);

  logic         busy;
  logic [W-1:0] v;
  logic [1:0]   pidx;
  logic [W-1:0] inv_sel;
  logic [W-1:0] lim_sel;
  logic [W-1:0] prod;

  always_comb begin
    case (pidx)
      P3: begin
        inv_sel = INV3;
        lim_sel = LIM3;
      end
      P5: begin
        inv_sel = INV5;
        lim_sel = LIM5;
      end
      P7: begin
        inv_sel = INV7;
        lim_sel = LIM7;
      end
      default: begin
        inv_sel = '0;
        lim_sel = '0;
      end
    endcase
  end

  // low W bits of v * d^-1; equals v / d exactly when d divides v
  assign prod = v * inv_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= value;
        pidx <= P2;
      end else if (busy) begin
        if (v == W'(1)) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          smooth <= 1'b1;
        end else if (pidx == P2) begin
          if (!v[0]) begin
            v <= v >> 1;
          end else begin
            pidx <= P3;
          end
        end else if (prod <= lim_sel) begin
          v <= prod;
        end else if (pidx == P7) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          smooth <= 1'b0;
        end else begin
          pidx <= pidx + 1'b1;
        end
      end
    end
  end

endmodule
